// File: sv/b85_pkg.sv
package b85_pkg;

  // stream constants
  localparam int unsigned RADIX       = 85;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned GROUP_DIGITS = 5;

  // input beat: one character
  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_beat_t;

  // output beat: one decoded byte or marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
    logic       bad_symbol;
    logic       no_data;
  } out_beat_t;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_BAD,
    KIND_LONE
  } b85_kind_t;

  // queue entry: a group of digits to turn into bytes, or a marker
  typedef struct packed {
    b85_kind_t   kind;
    logic [31:0] value;
    logic [2:0]  count;
    logic        fin;
  } b85_entry_t;

  // digit lookup result
  typedef struct packed {
    logic       valid;
    logic [6:0] digit;
  } b85_digit_t;

  // map an ascii code to its digit in the alphabet
  function automatic b85_digit_t digit_of(input logic [7:0] sym);
    b85_digit_t res;
    logic [7:0] tmp;
    res.valid = 1'b1;
    res.digit = 7'd0;
    tmp       = 8'd0;
    priority if (sym >= 8'h30 && sym <= 8'h39) begin
      tmp = sym - 8'd48;
    end else if (sym >= 8'h41 && sym <= 8'h5A) begin
      tmp = sym - 8'd55;
    end else if (sym >= 8'h61 && sym <= 8'h7A) begin
      tmp = sym - 8'd61;
    end else begin
      unique case (sym)
        8'h21:   tmp = 8'd62;
        8'h23:   tmp = 8'd63;
        8'h24:   tmp = 8'd64;
        8'h25:   tmp = 8'd65;
        8'h26:   tmp = 8'd66;
        8'h28:   tmp = 8'd67;
        8'h29:   tmp = 8'd68;
        8'h2A:   tmp = 8'd69;
        8'h2B:   tmp = 8'd70;
        8'h2D:   tmp = 8'd71;
        8'h3B:   tmp = 8'd72;
        8'h3C:   tmp = 8'd73;
        8'h3D:   tmp = 8'd74;
        8'h3E:   tmp = 8'd75;
        8'h3F:   tmp = 8'd76;
        8'h40:   tmp = 8'd77;
        8'h5E:   tmp = 8'd78;
        8'h5F:   tmp = 8'd79;
        8'h60:   tmp = 8'd80;
        8'h7B:   tmp = 8'd81;
        8'h7C:   tmp = 8'd82;
        8'h7D:   tmp = 8'd83;
        8'h7E:   tmp = 8'd84;
        default: res.valid = 1'b0;
      endcase
    end
    res.digit = tmp[6:0];
    return res;
  endfunction

  // 85 to the power of the missing digits of a partial group
  function automatic logic [31:0] pad_mul(input logic [2:0] count);
    logic [31:0] m;
    unique case (count)
      3'd2:    m = 32'd614125;
      3'd3:    m = 32'd7225;
      3'd4:    m = 32'd85;
      default: m = 32'd1;
    endcase
    return m;
  endfunction

endpackage

// File: sv/b85_fifo.sv
module b85_fifo #(
  parameter int DEPTH = b85_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b85_pkg::b85_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output b85_pkg::b85_entry_t  head_entry
);
  import b85_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b85_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/b85_front.sv
module b85_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b85_pkg::in_beat_t    in_beat,
  input  logic                 queue_full,
  output logic                 push,
  output b85_pkg::b85_entry_t  push_entry
);
  import b85_pkg::*;

  logic [31:0] group_value_r;
  logic [2:0]  digits_seen_r;
  logic        discarding_r;
  logic [31:0] group_value_nxt;
  logic [2:0]  digits_seen_nxt;
  logic        discarding_nxt;
  logic        accept;
  b85_digit_t  dig;
  logic [31:0] mac;
  logic [2:0]  cnt_inc;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign dig      = digit_of(in_beat.symbol);
  assign mac      = group_value_r * 32'(RADIX) + 32'(dig.digit);
  assign cnt_inc  = digits_seen_r + 3'd1;

  // classify the beat and update the group
  always_comb begin
    group_value_nxt  = group_value_r;
    digits_seen_nxt  = digits_seen_r;
    discarding_nxt   = discarding_r;
    push             = 1'b0;
    push_entry.kind  = KIND_DATA;
    push_entry.value = mac;
    push_entry.count = cnt_inc;
    push_entry.fin   = in_beat.final_symbol;
    if (accept) begin
      priority if (discarding_r) begin
        if (in_beat.final_symbol) begin
          discarding_nxt = 1'b0;
        end
      end else if (!dig.valid) begin
        push            = 1'b1;
        push_entry.kind = KIND_BAD;
        group_value_nxt = '0;
        digits_seen_nxt = '0;
        discarding_nxt  = !in_beat.final_symbol;
      end else if (cnt_inc == 3'(GROUP_DIGITS)) begin
        push            = 1'b1;
        group_value_nxt = '0;
        digits_seen_nxt = '0;
      end else if (in_beat.final_symbol) begin
        push            = 1'b1;
        if (cnt_inc == 3'd1) begin
          push_entry.kind = KIND_LONE;
        end
        group_value_nxt = '0;
        digits_seen_nxt = '0;
      end else begin
        group_value_nxt = mac;
        digits_seen_nxt = cnt_inc;
      end
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_value_r <= '0;
      digits_seen_r <= '0;
      discarding_r  <= 1'b0;
    end else begin
      group_value_r <= group_value_nxt;
      digits_seen_r <= digits_seen_nxt;
      discarding_r  <= discarding_nxt;
    end
  end

endmodule

// File: sv/b85_back.sv
module b85_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  b85_pkg::b85_entry_t  head_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b85_pkg::out_beat_t   out_beat
);
  import b85_pkg::*;

  logic        busy_r;
  logic [31:0] val_r;
  logic [2:0]  cnt_r;
  b85_kind_t   kind_r;
  logic        fin_r;
  logic        out_valid_r;
  out_beat_t   out_beat_r;
  logic        beat_take;
  logic        work_done;
  logic [31:0] padded;
  out_beat_t   beat;

  assign beat_take = busy_r && (!out_valid_r || !out_stall);
  assign work_done = beat_take && (cnt_r == 3'd1);
  assign pop       = head_valid && (!busy_r || work_done);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // pad a partial group with top digits: (v + 1) * 85^n - 1
  assign padded = (head_entry.value + 32'd1) * pad_mul(head_entry.count) - 32'd1;

  // next beat from the working group, most significant byte first
  always_comb begin
    beat.data_byte  = (kind_r == KIND_DATA) ? val_r[31:24] : 8'd0;
    beat.stream_end = (kind_r != KIND_DATA) || (fin_r && cnt_r == 3'd1);
    beat.bad_symbol = (kind_r == KIND_BAD);
    beat.no_data    = (kind_r == KIND_LONE);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (work_done) begin
        busy_r <= 1'b0;
      end
      if (beat_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working group and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head_entry.kind;
      fin_r  <= head_entry.fin;
      if (head_entry.kind == KIND_DATA) begin
        val_r <= padded;
        cnt_r <= head_entry.count - 3'd1;
      end else begin
        val_r <= '0;
        cnt_r <= 3'd1;
      end
    end else if (beat_take) begin
      val_r <= {val_r[23:0], 8'd0};
      cnt_r <= cnt_r - 3'd1;
    end
    if (beat_take) begin
      out_beat_r <= beat;
    end
  end

endmodule

// File: sv/base85_decoder.sv
// Streaming Base85 decoder, 85-symbol alphabet 0-9 A-Z a-z and punctuation.
// Input channel: in_valid / in_stall / in_beat, one character per beat,
// final_symbol marks the last character of a stream.
// Output channel: out_valid / out_stall / out_beat, one byte or marker per beat.
// Every fifth digit gives four bytes, most significant first. On the final
// character a partial group of k digits gives k-1 bytes, a lone digit gives
// one no_data end marker, and a character outside the alphabet gives one
// bad_symbol beat; later characters are dropped up to the final one.
// Throughput: one character per cycle while the queue has room; the output
// side moves one beat per cycle while out_stall is low, and a full group
// gives four beats. The first beat of an item passes through the queue, the
// pad multiply into the working group and the output register.
// A short queue of QUEUE_DEPTH entries sits between front and back; in_stall
// rises while it is full. A stalled output holds its beat and the queue fills.
// Reset clears the group state, the queue and out_valid; the output beat data is not reset.
module base85_decoder #(
  parameter int QUEUE_DEPTH = b85_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b85_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output b85_pkg::out_beat_t  out_beat
);
  import b85_pkg::*;

  logic       queue_full;
  logic       push;
  b85_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  b85_entry_t head_entry;

  // character classify and group accumulate
  b85_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  b85_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // padding and byte output
  b85_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat)
  );

endmodule
